/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned PRIO_W      = 8;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned OCC_W       = 5;
    localparam int unsigned DEPTH_DEF   = 16;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } slot_t;

    // Command broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic  insert;
        logic  remove;
        slot_t item;
    } cell_cmd_t;

endpackage

/* src/spq_if.sv */
// Handshake channels for request and response words of the priority queue.
interface spq_req_if;
    import spq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [0:0]                kind;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_prio;

    modport source (output valid, output kind, output item_value, output item_prio,
                    input ready);
    modport sink   (input valid, input kind, input item_value, input item_prio,
                    output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [PRIO_W-1:0]         removed_priority;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input occupancy, output ready);
endinterface

/* src/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 5
)
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [CNT_W-1:0] count,
    input  slot_t            left_slot,
    input  logic             left_shift,
    input  slot_t            right_slot,
    output slot_t            slot,
    output logic             shift
);

    slot_t slot_reg;
    slot_t slot_next;
    logic  occupied;
    logic  at_end;

    assign occupied = count > CNT_W'(INDEX);
    assign at_end   = count == CNT_W'(INDEX);

    // The cell lies in the insertion window if it holds a less urgent entry,
    // or if it is the first free slot.
    assign shift = (occupied && (slot_reg.prio > cmd.item.prio)) || at_end;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.insert && shift)
        begin
            slot_next = left_shift ? left_slot : cmd.item;
        end
        else if (cmd.remove)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: a chain of slot cells and a response register.
//
// Usage: request words arrive on req (kind, item_value, item_prio) and one
// response word leaves on rsp for each (status, removed_value, removed_priority,
// occupancy). An insert places its entry behind every stored entry of equal or
// lower priority number, so equal priorities leave in arrival order; a delete
// takes the front entry. Delete on an empty queue answers underflow, insert into
// a full queue answers overflow and the entry is dropped.
// The response is registered: it is valid in the cycle after its request is accepted.
// Throughput is one request per cycle while responses are taken, set by the row
// of DEPTH cells, each comparing its own priority with the new one in parallel and
// taking its left or right neighbour's entry in the same cycle.
// The response register decouples the two sides: a new request is taken while
// a response is pending, as long as that response is taken in the same cycle.
// When the receiver stalls, the response holds and req.ready falls.
// Reset empties the queue at once (only the entry count is cleared; slot
// contents are never read beyond the count) and drops any pending response.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic             accept;
    logic             is_insert;
    logic             is_delete;
    logic             full;
    logic             empty;
    logic             ins_ok;
    logic             del_ok;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    cell_cmd_t        cmd;

    slot_t cell_slot  [DEPTH];
    logic  cell_shift [DEPTH];

    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [PRIO_W-1:0]         prio_reg;
    logic [PRIO_W-1:0]         prio_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;

    // A request may enter whenever the response register is free or emptying.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_insert = kind_t'(req.kind) == KIND_INSERT;
    assign is_delete = kind_t'(req.kind) == KIND_DELETE;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign ins_ok    = accept && is_insert && !full;
    assign del_ok    = accept && is_delete && !empty;

    assign cmd.insert     = ins_ok;
    assign cmd.remove     = del_ok;
    assign cmd.item.value = req.item_value;
    assign cmd.item.prio  = req.item_prio;

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The chain: cell 0 is the front of the queue. On insert each cell in the
    // window takes its left neighbour's entry, or the new one where the window
    // opens; on delete every cell takes its right neighbour's entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slot_t left_slot;
        logic  left_shift;
        slot_t right_slot;

        if (i == 0)
        begin : g_front
            assign left_slot  = '0;
            assign left_shift = 1'b0;
        end
        else
        begin : g_inner
            assign left_slot  = cell_slot[i-1];
            assign left_shift = cell_shift[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_slot = cell_slot[i];
        end
        else
        begin : g_mid
            assign right_slot = cell_slot[i+1];
        end

        spq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .left_slot  (left_slot),
            .left_shift (left_shift),
            .right_slot (right_slot),
            .slot       (cell_slot[i]),
            .shift      (cell_shift[i])
        );
    end

    // Response word for the accepted request.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        value_next     = value_reg;
        prio_next      = prio_reg;
        occ_next       = occ_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_OK;
            value_next     = '0;
            prio_next      = '0;
            occ_next       = OCC_W'(count_next);
            if (is_insert && full)
            begin
                status_next = ST_OVERFLOW;
            end
            else if (is_delete && empty)
            begin
                status_next = ST_UNDERFLOW;
            end
            else if (is_delete)
            begin
                value_next = cell_slot[0].value;
                prio_next  = cell_slot[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        occ_reg    <= occ_next;
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.removed_value    = value_reg;
    assign rsp.removed_priority = prio_reg;
    assign rsp.occupancy        = occ_reg;

    // The entry count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // An insert into a full queue answers overflow in the next cycle.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_insert && full |=> rsp_valid_reg && status_reg == ST_OVERFLOW)
        else $error("full insert did not report overflow");

    // A successful delete lowers the count by exactly one.
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        del_ok |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not decrement the count");

    // An underflow response carries no removed entry.
    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg == ST_UNDERFLOW |-> value_reg == '0 && prio_reg == '0)
        else $error("underflow response carries data");

    // The two front cells stay in priority order whenever both are occupied.
    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> cell_slot[0].prio <= cell_slot[1].prio)
        else $error("front of queue out of order");

endmodule
